[rtl/core/pid_controller_antiwindup_top_defines.svh]
// ----------------------------------------------------------------------------
// pid controller assertion macros
// shared check forms for the microcoded pid sequencer
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define PID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid sequencer check failed");

// consequence in the cycle after the condition
`define PID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid sequencer check failed");

`endif

[rtl/core/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// pid controller package
// word types, microcode fields and the control program of the sequencer
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // full product width of the shared 33x33 signed multiplier
  localparam int PROD_W = 66;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured_angle;
    logic        [31:0] step_time;
    logic               clear;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
    logic signed [31:0] drive;
  } out_word_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_GAIN_P    = 2'd0,
    REG_GAIN_I    = 2'd1,
    REG_GAIN_D    = 2'd2,
    REG_INT_LIMIT = 2'd3
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // register write performed by a step
  typedef enum logic [2:0] {
    W_NONE,
    W_ERR,
    W_INTEG,
    W_DERIV,
    W_PT,
    W_IT,
    W_DT,
    W_OUT
  } wr_op_t;

  // multiplier operand pair
  typedef enum logic [1:0] {
    MUL_DT,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  // jump conditions
  typedef enum logic [1:0] {
    J_NONE,
    J_DT_ZERO,
    J_DIV_BUSY,
    J_OUT_FULL
  } jmp_cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_ERR   = 4'd0;
  localparam step_t STEP_MULDT = 4'd1;
  localparam step_t STEP_INTEG = 4'd2;
  localparam step_t STEP_DIV   = 4'd3;
  localparam step_t STEP_MULP  = 4'd4;
  localparam step_t STEP_PT    = 4'd5;
  localparam step_t STEP_IT    = 4'd6;
  localparam step_t STEP_DT    = 4'd7;
  localparam step_t STEP_OUT   = 4'd8;

  typedef struct packed {
    wr_op_t    wr;
    mul_sel_t  mul;
    logic      div_start;
    jmp_cond_t jmp;
    step_t     target;
    logic      last;
  } ctrl_word_t;

  // control program, one word per step
  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    w = '{wr: W_NONE, mul: MUL_DT, div_start: 1'b0, jmp: J_NONE,
          target: STEP_ERR, last: 1'b0};
    unique case (s)
      STEP_ERR:   w.wr = W_ERR;
      STEP_MULDT: begin
        w.mul    = MUL_DT;
        w.jmp    = J_DT_ZERO;
        w.target = STEP_MULP;
      end
      STEP_INTEG: begin
        w.wr        = W_INTEG;
        w.div_start = 1'b1;
      end
      STEP_DIV: begin
        w.wr     = W_DERIV;
        w.jmp    = J_DIV_BUSY;
        w.target = STEP_DIV;
      end
      STEP_MULP:  w.mul = MUL_P;
      STEP_PT: begin
        w.wr  = W_PT;
        w.mul = MUL_I;
      end
      STEP_IT: begin
        w.wr  = W_IT;
        w.mul = MUL_D;
      end
      STEP_DT:    w.wr = W_DT;
      STEP_OUT: begin
        w.wr     = W_OUT;
        w.jmp    = J_OUT_FULL;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default:    w.last = 1'b1;
    endcase
    return w;
  endfunction

  // saturate a full width value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(PROD_W'(32'sh7fff_ffff))) begin
      r = 32'sh7fff_ffff;
    end else if (v < -$signed(PROD_W'(33'sh0_8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/pid_controller_antiwindup_top.sv]
// a word runs the steps err, muldt, integ, div, mulp, pt, it, dt and out; div is
// the bit-serial restoring divider, with 32 + FRAC_BITS quotient bits (Q16.16
// at the default); a zero step time skips integ and div; a clear word gives no
// result; a new word is taken only once the last has finished its out step;
// a waiting result holds the last step and the input stalls until it is taken
// reset (rst, synchronous): gains zero, limit 100.0, integral and last error zero
// ----------------------------------------------------------------------------
// pid controller with integral clamp
// microcoded sequencer over a shared multiplier and a serial divider
// ----------------------------------------------------------------------------
`include "pid_controller_antiwindup_top_defines.svh"

module pid_controller_antiwindup_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pidaw_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pidaw_pkg::out_word_t out_data
);

  localparam int DW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int PW    = pidaw_pkg::PROD_W;
  localparam logic [30:0]   LIMIT_RESET = 31'(100 << FRAC_BITS);
  localparam logic [DW-1:0] Q_NEG_MAX   = DW'(33'h0_8000_0000);
  localparam logic [DW-1:0] Q_POS_MAX   = DW'(33'h0_7fff_ffff);

  // configuration
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [30:0]        integral_limit;

  // state and datapath registers
  pidaw_pkg::seq_state_t seq_state, seq_state_next;
  pidaw_pkg::step_t      step, step_next;
  pidaw_pkg::in_word_t   in_reg;
  logic signed [31:0]    integral;
  logic signed [31:0]    last_error;
  logic signed [31:0]    err;
  logic signed [31:0]    deriv;
  logic signed [31:0]    p_term;
  logic signed [31:0]    i_term;
  logic signed [31:0]    d_term;
  logic signed [PW-1:0]  prod;

  // divider
  logic [32:0]      div_rem;
  logic [DW-1:0]    div_quo;
  logic [CNT_W-1:0] div_cnt;
  logic             div_neg;
  logic             div_busy;

  // combinational
  pidaw_pkg::ctrl_word_t ctrl;
  logic                  run;
  logic                  in_take;
  logic                  out_take;
  logic                  out_full;
  logic                  jump;
  logic signed [32:0]    mul_a, mul_b;
  logic signed [PW-1:0]  acc;
  logic signed [PW-1:0]  lim_ext;
  logic signed [PW-1:0]  integ_ext;
  logic signed [PW-1:0]  shifted;
  logic signed [32:0]    diff;
  logic [31:0]           diff_mag;
  logic [32:0]           trial;
  logic                  trial_ge;
  logic signed [31:0]    deriv_q;
  logic signed [33:0]    term_sum;

  assign ctrl     = pidaw_pkg::ucode_rom(step);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_full = out_valid && out_stall;
  assign div_busy = (div_cnt != '0);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (pidaw_pkg::reg_index_t'(cfg_index))
        pidaw_pkg::REG_GAIN_P:    gain_p <= cfg_data;
        pidaw_pkg::REG_GAIN_I:    gain_i <= cfg_data;
        pidaw_pkg::REG_GAIN_D:    gain_d <= cfg_data;
        pidaw_pkg::REG_INT_LIMIT: integral_limit <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // jump condition of the current step
  always_comb begin
    case (ctrl.jmp)
      pidaw_pkg::J_DT_ZERO:  jump = (in_reg.step_time == '0);
      pidaw_pkg::J_DIV_BUSY: jump = div_busy;
      pidaw_pkg::J_OUT_FULL: jump = out_full;
      default:               jump = 1'b0;
    endcase
  end

  // sequencer next state
  always_comb begin
    seq_state_next = seq_state;
    step_next      = step;
    unique case (seq_state)
      pidaw_pkg::ST_IDLE: begin
        step_next = pidaw_pkg::STEP_ERR;
        if (in_take && !in_data.clear) begin
          seq_state_next = pidaw_pkg::ST_RUN;
        end
      end
      pidaw_pkg::ST_RUN: begin
        if (jump) begin
          step_next = ctrl.target;
        end else if (ctrl.last) begin
          seq_state_next = pidaw_pkg::ST_IDLE;
          step_next      = pidaw_pkg::STEP_ERR;
        end else begin
          step_next = step + 4'd1;
        end
      end
      default: begin
        seq_state_next = pidaw_pkg::ST_IDLE;
        step_next      = pidaw_pkg::STEP_ERR;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    unique case (seq_state)
      pidaw_pkg::ST_RUN: begin
        run      = 1'b1;
        in_stall = 1'b1;
      end
      default: begin
        run      = 1'b0;
        in_stall = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= pidaw_pkg::ST_IDLE;
      step      <= pidaw_pkg::STEP_ERR;
    end else begin
      seq_state <= seq_state_next;
      step      <= step_next;
    end
  end

  // multiplier operand select
  always_comb begin
    case (ctrl.mul)
      pidaw_pkg::MUL_DT: begin
        mul_a = 33'(err);
        mul_b = $signed({1'b0, in_reg.step_time});
      end
      pidaw_pkg::MUL_P: begin
        mul_a = 33'(gain_p);
        mul_b = 33'(err);
      end
      pidaw_pkg::MUL_I: begin
        mul_a = 33'(gain_i);
        mul_b = 33'(integral);
      end
      default: begin
        mul_a = 33'(gain_d);
        mul_b = 33'(deriv);
      end
    endcase
  end

  // integral update with clamp, and the derivative difference
  always_comb begin
    shifted   = prod >>> FRAC_BITS;
    integ_ext = PW'(integral);
    lim_ext   = $signed({{(PW - 31){1'b0}}, integral_limit});
    acc       = shifted + integ_ext;
    if (acc > lim_ext) begin
      acc = lim_ext;
    end else if (acc < -lim_ext) begin
      acc = -lim_ext;
    end
    diff     = 33'(err) - 33'(last_error);
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // divider step, quotient saturation and the sum of the three terms
  always_comb begin
    trial    = {div_rem[31:0], div_quo[DW-1]};
    trial_ge = (trial >= {1'b0, in_reg.step_time});
    if (div_neg) begin
      deriv_q = (div_quo > Q_NEG_MAX) ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
    end else begin
      deriv_q = (div_quo > Q_POS_MAX) ? 32'sh7fff_ffff : $signed(div_quo[31:0]);
    end
    term_sum = 34'(p_term) + 34'(i_term) + 34'(d_term);
  end

  // serial restoring divider: (|diff| << FRAC_BITS) / step_time
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (run && ctrl.div_start) begin
      div_cnt <= CNT_W'(DW);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (run && ctrl.div_start) begin
      div_rem <= '0;
      div_quo <= {diff_mag, {FRAC_BITS{1'b0}}};
      div_neg <= diff[32];
    end else if (div_busy) begin
      div_rem <= trial_ge ? (trial - {1'b0, in_reg.step_time}) : trial;
      div_quo <= {div_quo[DW-2:0], trial_ge};
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg <= in_data;
    end
  end

  // datapath writes
  always_ff @(posedge clk) begin
    if (rst) begin
      integral   <= '0;
      last_error <= '0;
    end else if (in_take && in_data.clear) begin
      integral   <= '0;
      last_error <= '0;
    end else if (run) begin
      case (ctrl.wr)
        pidaw_pkg::W_INTEG: integral <= acc[31:0];
        pidaw_pkg::W_OUT:   if (!out_full) last_error <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      case (ctrl.wr)
        pidaw_pkg::W_ERR: begin
          err   <= pidaw_pkg::sat32(PW'(33'(in_reg.target) - 33'(in_reg.measured_angle)));
          deriv <= '0;
        end
        pidaw_pkg::W_DERIV: if (!div_busy) deriv <= deriv_q;
        pidaw_pkg::W_PT:    p_term <= pidaw_pkg::sat32(shifted);
        pidaw_pkg::W_IT:    i_term <= pidaw_pkg::sat32(shifted);
        pidaw_pkg::W_DT:    d_term <= pidaw_pkg::sat32(shifted);
        pidaw_pkg::W_OUT: begin
          if (!out_full) begin
            out_data.p_term <= p_term;
            out_data.i_term <= i_term;
            out_data.d_term <= d_term;
            out_data.drive  <= pidaw_pkg::sat32(PW'(term_sum));
          end
        end
        default: ;
      endcase
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run && ctrl.wr == pidaw_pkg::W_OUT && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `PID_ASSERT_NEXT(a_start_run, in_take && !in_data.clear,
    seq_state == pidaw_pkg::ST_RUN && step == pidaw_pkg::STEP_ERR)
  `PID_ASSERT_NEXT(a_integ_clamped, run && ctrl.wr == pidaw_pkg::W_INTEG,
    integ_ext <= lim_ext && integ_ext >= -lim_ext)
  `PID_ASSERT_NOW(a_div_in_run, div_busy, seq_state == pidaw_pkg::ST_RUN)
  `PID_ASSERT_NOW(a_out_from_last, $rose(out_valid), $past(step) == pidaw_pkg::STEP_OUT)

endmodule

[dv/tb_pid_controller_antiwindup_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid controller with integral clamp: testbench
// a queue-fed driver and a checking monitor run the block against a local
// fixed point predictor through directed words, random tracking-loop words,
// back pressure and several register settings
// ----------------------------------------------------------------------------
module tb_pid_controller_antiwindup_top;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT = 1200;
  localparam int HOLD_CYCLES = 400;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = pidaw_pkg::REG_GAIN_P;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pidaw_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pidaw_pkg::out_word_t out_data;

  pid_controller_antiwindup_top #(.FRAC_BITS(FRAC)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // predictor registers and state
  longint kp = 0;
  longint ki = 0;
  longint kd = 0;
  longint int_limit = 64'sd100 <<< FRAC;
  longint integ_acc = 0;
  longint prev_err = 0;

  pidaw_pkg::in_word_t  pending_words[$];
  pidaw_pkg::out_word_t expected_terms[$];
  pidaw_pkg::out_word_t predicted;
  int          words_accepted = 0;
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // pid terms for one word; returns 0 for a clear word
  function automatic bit compute_pid_terms(input pidaw_pkg::in_word_t w,
                                           output pidaw_pkg::out_word_t r);
    longint err, deriv, acc, diff, p, i, d, sum;
    longint unsigned dt, mag, q;
    r = '0;
    if (w.clear) begin
      integ_acc = 0;
      prev_err = 0;
      return 1'b0;
    end
    dt = {32'd0, w.step_time};
    err = sat_word(longint'($signed(w.target)) - longint'($signed(w.measured_angle)));
    deriv = 0;
    if (dt != 0) begin
      acc = integ_acc + ((err * longint'(dt)) >>> FRAC);
      diff = err - prev_err;
      mag = (diff < 0) ? -diff : diff;
      q = (mag << FRAC) / dt;
      // anti-windup clamp
      if (acc > int_limit) acc = int_limit;
      if (acc < -int_limit) acc = -int_limit;
      integ_acc = acc;
      if (diff < 0) begin
        deriv = (q > 64'd2147483648) ? WORD_MIN : -longint'(q);
      end else begin
        deriv = (q > 64'd2147483647) ? WORD_MAX : longint'(q);
      end
    end
    p = sat_word((kp * err) >>> FRAC);
    i = sat_word((ki * integ_acc) >>> FRAC);
    d = sat_word((kd * deriv) >>> FRAC);
    sum = sat_word(p + i + d);
    prev_err = err;
    r.p_term = p[31:0];
    r.i_term = i[31:0];
    r.d_term = d[31:0];
    r.drive = sum[31:0];
    return 1'b1;
  endfunction

  // mostly tracking-loop samples, some raw words, some clears
  function automatic pidaw_pkg::in_word_t random_word();
    pidaw_pkg::in_word_t w;
    int unsigned pick;
    int setpoint;
    pick = $urandom_range(99);
    w.target = $urandom;
    w.measured_angle = $urandom;
    w.step_time = $urandom;
    w.clear = 1'b0;
    if (pick < 5) begin
      w.clear = 1'b1;
    end else if (pick >= 20) begin
      setpoint = $signed($urandom) >>> 7;
      w.target = setpoint;
      w.measured_angle = setpoint + ($signed($urandom) >>> 12);
      w.step_time = (pick < 32) ? 32'd0 : $urandom_range(1, 32'h0001_0000);
    end
    return w;
  endfunction

  task automatic push_word(input logic [31:0] tgt, input logic [31:0] meas,
                           input logic [31:0] dt, input logic clr);
    pidaw_pkg::in_word_t w;
    w.target = tgt;
    w.measured_angle = meas;
    w.step_time = dt;
    w.clear = clr;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input pidaw_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pidaw_pkg::REG_GAIN_P:    kp = longint'($signed(val));
      pidaw_pkg::REG_GAIN_I:    ki = longint'($signed(val));
      pidaw_pkg::REG_GAIN_D:    kd = longint'($signed(val));
      pidaw_pkg::REG_INT_LIMIT: int_limit = longint'({1'b0, val[30:0]});
      default:                  ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // extremes, full random gains and moderate loop tunings in turn
  task automatic apply_settings(input int k);
    case (k % 5)
      0: begin
        write_reg(pidaw_pkg::REG_GAIN_P, 32'h7fff_ffff);
        write_reg(pidaw_pkg::REG_GAIN_I, 32'h7fff_ffff);
        write_reg(pidaw_pkg::REG_GAIN_D, 32'h7fff_ffff);
        write_reg(pidaw_pkg::REG_INT_LIMIT, 32'h7fff_ffff);
      end
      1: begin
        write_reg(pidaw_pkg::REG_GAIN_P, 32'h8000_0000);
        write_reg(pidaw_pkg::REG_GAIN_I, 32'h8000_0000);
        write_reg(pidaw_pkg::REG_GAIN_D, 32'h8000_0000);
        write_reg(pidaw_pkg::REG_INT_LIMIT, 32'h0000_0000);
      end
      2: begin
        write_reg(pidaw_pkg::REG_GAIN_P, $urandom);
        write_reg(pidaw_pkg::REG_GAIN_I, $urandom);
        write_reg(pidaw_pkg::REG_GAIN_D, $urandom);
        // top bit is outside the 31-bit limit register
        write_reg(pidaw_pkg::REG_INT_LIMIT, 32'hffff_ffff);
      end
      default: begin
        write_reg(pidaw_pkg::REG_GAIN_P, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        write_reg(pidaw_pkg::REG_GAIN_I, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        write_reg(pidaw_pkg::REG_GAIN_D, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
        write_reg(pidaw_pkg::REG_INT_LIMIT, $urandom_range(0, 32'h00c8_0000));
      end
    endcase
  endtask

  // wait for every word to be taken and every result to come back
  task automatic drain();
    while (pending_words.size() != 0 || expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // driver: offers the head of the pending queue, predicts on accept
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (compute_pid_terms(in_data, predicted)) expected_terms.push_back(predicted);
        void'(pending_words.pop_front());
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, one long hold-off, result checks
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_terms.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, got %h", $time, out_data);
          mismatch_cnt++;
        end else begin
          check_field("p_term", expected_terms[0].p_term, out_data.p_term);
          check_field("i_term", expected_terms[0].i_term, out_data.i_term);
          check_field("d_term", expected_terms[0].d_term, out_data.d_term);
          check_field("drive", expected_terms[0].drive, out_data.drive);
          void'(expected_terms.pop_front());
        end
      end
      if (!hold_done && words_accepted == HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // unit-ish gains, limit left at its reset value of 100.0
    write_reg(pidaw_pkg::REG_GAIN_P, 32'h0001_0000);
    write_reg(pidaw_pkg::REG_GAIN_I, 32'h0000_8000);
    write_reg(pidaw_pkg::REG_GAIN_D, 32'h0000_4000);
    push_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    // error saturates high with the shortest step, then low with the longest
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b0);
    push_word(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    // one lsb negative error: product rounds toward minus infinity
    push_word(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 1'b0);
    // clear wins over every other field
    push_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    // derivative saturates both ways
    push_word(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001, 1'b0);
    push_word(32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
    push_word(32'h0005_0000, 32'h0002_0000, 32'd655, 1'b0);
    // zero step time: integral kept, derivative zero
    push_word(32'h0005_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);
    push_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    // wind the integral up into the clamp
    push_word(32'h0032_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_word(32'h0032_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_word(32'h0032_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    drain();

    // lowered limit only bites on the next nonzero step
    write_reg(pidaw_pkg::REG_INT_LIMIT, 32'h000a_0000);
    push_word(32'h0032_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_word(32'h0032_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_word(32'hffce_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_word(32'hffce_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_word(32'hffce_0000, 32'h0000_0000, 32'h0000_8000, 1'b0);
    push_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    drain();

    // random part: receiver-idle, sender-idle, then no idling
    for (int blk = 0; blk < 15; blk++) begin
      apply_settings(blk);
      if (blk < 5) begin
        send_idle_pct = 15;
        recv_idle_pct = 73;
      end else if (blk < 10) begin
        send_idle_pct = 73;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (100) pending_words.push_back(random_word());
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[pid_controller_antiwindup_top.f]
+incdir+rtl/core
rtl/core/pidaw_pkg.sv
rtl/core/pid_controller_antiwindup_top.sv
dv/tb_pid_controller_antiwindup_top.sv
